### rtl/hxd_pkg.sv
// Shared types and constants for the hex text to bytes decoder.
// No dependencies; imported by every module of the block.
package hxd_pkg;

  localparam int unsigned MAX_BYTES = 4096;
  localparam logic [12:0] CAP_LIMIT = 13'(MAX_BYTES);

  // Result queue depth; one item writes at most two results.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ZERO = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BAD   = 3'd1,
    ST_ODD   = 3'd2,
    ST_OVF   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  held_nibble;
    logic        nibble_pending;
    logic        lone_first_pending;
    logic [12:0] written_count;
    logic [12:0] capacity_held;
  } dec_state_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    status_t     status;
    logic [12:0] bytes_written;
  } result_t;

  // Up to two results produced by one character.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

### rtl/hxd_step.sv
// Per-character decode: next decoder state and the results one character yields.
// Purely combinational; depends on hxd_pkg.
module hxd_step import hxd_pkg::*; (
  input  dec_state_t cur,
  input  logic [7:0] char_code,
  input  logic       first_char,
  input  logic       last_char,
  input  logic       length_odd,
  input  logic [12:0] capacity,
  output dec_state_t nxt,
  output step_out_t  res
);

  // bit 4 set when the character is a hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = '0;
    if (c >= "0" && c <= "9") v = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") v = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") v = {1'b1, 4'(c - "A" + 8'd10)};
    return v;
  endfunction

  function automatic void put(inout step_out_t o, input logic is_st, input logic [7:0] b,
                              input status_t st, input logic [12:0] cnt);
    result_t r;
    r.is_status     = is_st;
    r.data_byte     = b;
    r.status        = st;
    r.bytes_written = cnt;
    if (o.count == 2'd0) o.res0 = r;
    else o.res1 = r;
    o.count = o.count + 2'd1;
  endfunction

  function automatic void do_digit(inout dec_state_t s, inout step_out_t o,
                                   input logic [7:0] c, input logic last);
    logic [4:0] hv;
    logic       stop;
    status_t    fin;
    hv   = hex_val(c);
    stop = 1'b0;
    if (!hv[4]) begin
      put(o, 1'b1, 8'd0, ST_BAD, s.written_count);
      s.phase = PH_IDLE;
      stop = 1'b1;
    end else if (s.lone_first_pending) begin
      s.lone_first_pending = 1'b0;
      if (s.capacity_held == 13'd0) begin
        put(o, 1'b1, 8'd0, ST_OVF, s.written_count);
        s.phase = PH_IDLE;
        stop = 1'b1;
      end else begin
        s.written_count = s.written_count + 13'd1;
        put(o, 1'b0, {4'd0, hv[3:0]}, ST_OK, s.written_count);
      end
    end else if (!s.nibble_pending) begin
      s.held_nibble    = hv[3:0];
      s.nibble_pending = 1'b1;
    end else begin
      s.nibble_pending = 1'b0;
      if (s.written_count >= s.capacity_held) begin
        put(o, 1'b1, 8'd0, ST_OVF, s.written_count);
        s.phase = PH_IDLE;
        stop = 1'b1;
      end else begin
        s.written_count = s.written_count + 13'd1;
        put(o, 1'b0, {s.held_nibble, hv[3:0]}, ST_OK, s.written_count);
      end
    end
    if (!stop && last) begin
      if (s.nibble_pending) fin = ST_ODD;
      else if (s.written_count == 13'd0) fin = ST_EMPTY;
      else fin = ST_OK;
      put(o, 1'b1, 8'd0, fin, s.written_count);
      s.phase = PH_IDLE;
    end
  endfunction

  always_comb begin
    dec_state_t s;
    step_out_t  o;
    s = cur;
    o = '0;
    if (first_char) begin
      s.written_count      = 13'd0;
      s.held_nibble        = 4'd0;
      s.nibble_pending     = 1'b0;
      s.lone_first_pending = length_odd;
      s.capacity_held      = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
      if (char_code == "0" && !last_char) begin
        s.phase = PH_ZERO;
      end else begin
        s.phase = PH_RUN;
        do_digit(s, o, char_code, last_char);
      end
    end else if (cur.phase == PH_ZERO) begin
      s.phase = PH_RUN;
      if (char_code == "x" || char_code == "X") begin
        if (last_char) begin
          put(o, 1'b1, 8'd0, ST_EMPTY, s.written_count);
          s.phase = PH_IDLE;
        end
      end else begin
        // the held '0' was a real digit
        do_digit(s, o, "0", 1'b0);
        if (s.phase == PH_RUN) do_digit(s, o, char_code, last_char);
      end
    end else if (cur.phase == PH_RUN) begin
      do_digit(s, o, char_code, last_char);
    end
    nxt = s;
    res = o;
  end

endmodule

### rtl/hxd_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on hxd_pkg.
module hxd_queue import hxd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  step_out_t push,
  input  logic      pop,
  output logic      room,
  output logic      not_empty,
  output result_t   head
);

  result_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;

  assign room      = count <= QCNT_W'(QDEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_comb begin
    count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.count == 2'd2) mem[wr_ptr + QPTR_W'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (32'(count) + 32'(push.count) <= 32'(QDEPTH)))
    else $error("result queue overrun");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |=> not_empty)
    else $error("pushed result not visible");

endmodule

### rtl/hex_text_to_bytes_decoder_top.sv
// Top level of the hex text to bytes decoder.
// Depends on hxd_pkg, hxd_step and hxd_queue.
//
// Usage:
//   Characters arrive on the char channel (char_valid/char_ready) with
//   char_code, first_char, last_char, length_odd and capacity; length_odd and
//   capacity are sampled with first_char. Results leave on the result channel
//   (result_valid/result_ready): data bytes with is_status low, then one
//   status item ending each string with bytes_written.
//   A result is registered in the queue at its character's transaction and
//   offered after those ahead of it. Throughput: one character per cycle while
//   char_ready is high. A character yields at most two results, kept in a
//   four-entry queue; char_ready is high while at least two slots are free,
//   so a stalled receiver can leave up to two results waiting while characters
//   keep flowing, and char_ready drops once three or more results are queued.
//   Reset clears the decoder state (no string open) and empties the queue.
//   Capacity above 4096 counts as 4096.
module hex_text_to_bytes_decoder_top import hxd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_code,
  input  logic        first_char,
  input  logic        last_char,
  input  logic        length_odd,
  input  logic [12:0] capacity,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        is_status,
  output logic [7:0]  data_byte,
  output logic [2:0]  status,
  output logic [12:0] bytes_written
);

  dec_state_t st;
  dec_state_t st_next;
  step_out_t  step_res;
  step_out_t  push;
  result_t    head;
  logic       room;
  logic       accept;

  assign char_ready = room;
  assign accept     = char_valid && char_ready;

  hxd_step u_step (
    .cur        (st),
    .char_code  (char_code),
    .first_char (first_char),
    .last_char  (last_char),
    .length_odd (length_odd),
    .capacity   (capacity),
    .nxt        (st_next),
    .res        (step_res)
  );

  always_comb begin
    push = step_res;
    if (!accept) push.count = 2'd0;
  end

  // all-zero state is phase idle with nothing pending
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  hxd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (result_valid && result_ready),
    .room      (room),
    .not_empty (result_valid),
    .head      (head)
  );

  assign is_status     = head.is_status;
  assign data_byte     = head.data_byte;
  assign status        = head.status;
  assign bytes_written = head.bytes_written;

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> !push.res0.is_status)
    else $error("status result followed by another result");

  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2 && push.res1.is_status) ||
    (push.count == 2'd1 && push.res0.is_status) |=> st.phase == PH_IDLE)
    else $error("string still open after its status");

  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    st.written_count <= st.capacity_held)
    else $error("written count beyond capacity");

endmodule
